>>> design/rssi_db_pkg.sv
// Shared constants and types for the RSSI power-in-dB block.
// Used by rssi_db_front, rssi_db_queue, rssi_db_back and block_rssi_power_db.
package rssi_db_pkg;

    localparam int SAMPLE_W   = 16;           // input sample width
    localparam int SQ_W       = 2 * SAMPLE_W - 1; // width of one square (max 2^30)
    localparam int PWR_W      = SQ_W + 1;     // I*I + Q*Q
    localparam int SUM_W      = 47;           // block power accumulator
    localparam int CNT_W      = 16;           // sample counter / reported count
    localparam int MAX_BLOCK  = 32768;        // forced block end at this count

    localparam int FRAC_W     = 16;           // log2 fraction bits
    localparam int EXP_W      = 6;            // log2 integer part (0..46)
    localparam int LG_W       = EXP_W + FRAC_W;
    localparam int MANT_W     = 31;           // normalized mantissa [2^30, 2^31)
    localparam int ITER_W     = 4;            // counts FRAC_W squaring steps

    // log2 of full scale power: 2*(SAMPLE_W-1) in Q.16
    localparam int LOG_BIAS   = 2 * (SAMPLE_W - 1) * 65536;
    localparam int DB_PER_LOG2 = 197283;      // round(10*log10(2) * 2^16)
    localparam int OFFSET_20DB = 5120;        // 20 dB in 1/256 dB

    localparam int LEVEL_W    = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W    = $clog2(QUEUE_DEPTH + 1);

    // One finished block, handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0] power_sum;
        logic [CNT_W-1:0] sample_count;
    } blk_t;

endpackage

>>> design/rssi_db_front.sv
// Front end: squares each sample, accumulates block power and count.
// Depends on rssi_db_pkg; pushes finished blocks into rssi_db_queue.
module rssi_db_front
    import rssi_db_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic signed [SAMPLE_W-1:0] sample_i,
    input  logic signed [SAMPLE_W-1:0] sample_q,
    input  logic                       last_sample,
    output logic                       push_valid,
    output blk_t                       push_data,
    input  logic                       q_full
);

    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic [SQ_W-1:0]   sqi_reg;
    logic [SQ_W-1:0]   sqq_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [2*SAMPLE_W-1:0] prod_i;
    logic [2*SAMPLE_W-1:0] prod_q;
    logic [PWR_W-1:0]  pwr;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W:0]    cnt_next;
    logic              s1_end;
    logic              s1_fire;

    assign prod_i = sample_i * sample_i;
    assign prod_q = sample_q * sample_q;

    assign pwr      = {1'b0, sqi_reg} + {1'b0, sqq_reg};
    assign sum_next = sum_reg + {{(SUM_W-PWR_W){1'b0}}, pwr};
    assign cnt_next = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign s1_end   = s1_last_reg || (cnt_next >= (CNT_W+1)'(MAX_BLOCK));

    // an ending sample needs queue room; others always go through
    assign s1_fire  = s1_valid_reg && (!s1_end || !q_full);
    assign s_tready = !s1_valid_reg || s1_fire;

    assign push_valid             = s1_fire && s1_end;
    assign push_data.power_sum    = sum_next;
    assign push_data.sample_count = cnt_next[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_fire) begin
                if (s1_end) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            sqi_reg     <= prod_i[SQ_W-1:0];
            sqq_reg     <= prod_q[SQ_W-1:0];
            s1_last_reg <= last_sample;
        end
    end

endmodule

>>> design/rssi_db_queue.sv
// Short register queue of finished blocks between front and back.
// Depends on rssi_db_pkg (blk_t, QUEUE_DEPTH).
module rssi_db_queue
    import rssi_db_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  blk_t push_data,
    output logic q_full,
    output logic q_valid,
    output blk_t q_data,
    input  logic q_pop
);

    blk_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;

    logic do_push;
    logic do_pop;

    assign q_full  = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push_valid && !q_full;
    assign do_pop  = q_pop && q_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + QFILL_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - QFILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= QFILL_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");
    a_no_lost_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_full)
        else $error("block pushed into full queue");
    a_fill_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (fill_reg == $past(fill_reg) + QFILL_W'(1)))
        else $error("queue fill count not advanced on push");
`endif

endmodule

>>> design/rssi_db_back.sv
// Back end: log2 of block sum and count by shared normalize/square unit,
// scale to 1/256 dB, saturate, and hold the result in the output register.
// Depends on rssi_db_pkg; pops blocks from rssi_db_queue.
module rssi_db_back
    import rssi_db_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  blk_t                      q_data,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic signed [LEVEL_W-1:0] rssi_level,
    output logic        [CNT_W-1:0]   block_count
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DIFF = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam int D_W = 24;
    localparam int T_W = D_W + 19;

    logic [2:0]              state_reg,  state_next;
    logic                    phase_reg,  phase_next;   // 0: sum, 1: count
    logic                    zero_reg,   zero_next;
    logic [SUM_W-1:0]        norm_reg,   norm_next;
    logic [EXP_W-1:0]        exp_reg,    exp_next;
    logic [MANT_W-1:0]       mant_reg,   mant_next;
    logic [2*MANT_W-1:0]     prod_reg,   prod_next;
    logic [FRAC_W-1:0]       frac_reg,   frac_next;
    logic [ITER_W-1:0]       iter_reg,   iter_next;
    logic [LG_W-1:0]         lg_sum_reg, lg_sum_next;
    logic [LG_W-1:0]         lg_cnt_reg, lg_cnt_next;
    logic [CNT_W-1:0]        cnt_reg,    cnt_next;
    logic signed [D_W-1:0]   d_reg,      d_next;
    logic signed [T_W-1:0]   t_reg,      t_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [LEVEL_W-1:0]      level_reg,  level_next;
    logic [CNT_W-1:0]        bcnt_reg,   bcnt_next;

    logic [MANT_W:0]         sq_top;
    logic [FRAC_W-1:0]       frac_step;
    logic [LG_W-1:0]         lg_done;
    logic                    slot_free;
    logic signed [T_W:0]     t_rnd;
    logic signed [T_W-24:0]  lvl_q;
    logic signed [T_W-23:0]  lvl_off;
    logic [LEVEL_W-1:0]      lvl_sat;

    assign slot_free = !m_tvalid_reg || m_tready;

    // one squaring step: (m*m) >> 30, renormalized with one fraction bit out
    assign sq_top    = prod_reg[2*MANT_W-1:MANT_W-1];
    assign frac_step = {frac_reg[FRAC_W-2:0], sq_top[MANT_W]};
    assign lg_done   = {exp_reg, frac_step};

    // round to 1/256 dB, remove 20 dB, clamp to 16 bits
    assign t_rnd   = {t_reg[T_W-1], t_reg} + (T_W+1)'(32'sd8388608);
    assign lvl_q   = t_rnd[T_W:24];
    assign lvl_off = {lvl_q[T_W-24], lvl_q} - (T_W-22)'(OFFSET_20DB);
    always_comb begin
        if (zero_reg || lvl_off < -(T_W-22)'(32768)) begin
            lvl_sat = 16'h8000;
        end else if (lvl_off > (T_W-22)'(32767)) begin
            lvl_sat = 16'h7FFF;
        end else begin
            lvl_sat = lvl_off[LEVEL_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        zero_next     = zero_reg;
        norm_next     = norm_reg;
        exp_next      = exp_reg;
        mant_next     = mant_reg;
        prod_next     = prod_reg;
        frac_next     = frac_reg;
        iter_next     = iter_reg;
        lg_sum_next   = lg_sum_reg;
        lg_cnt_next   = lg_cnt_reg;
        cnt_next      = cnt_reg;
        d_next        = d_reg;
        t_next        = t_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        level_next    = level_reg;
        bcnt_next     = bcnt_reg;
        q_pop         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    norm_next  = q_data.power_sum;
                    cnt_next   = q_data.sample_count;
                    exp_next   = EXP_W'(SUM_W - 1);
                    phase_next = 1'b0;
                    zero_next  = (q_data.power_sum == '0);
                    state_next = (q_data.power_sum == '0) ? ST_OUT : ST_NORM;
                end
            end
            ST_NORM: begin
                if (norm_reg[SUM_W-1 -: 8] == '0) begin
                    norm_next = {norm_reg[SUM_W-9:0], 8'b0};
                    exp_next  = exp_reg - EXP_W'(8);
                end else if (!norm_reg[SUM_W-1]) begin
                    norm_next = {norm_reg[SUM_W-2:0], 1'b0};
                    exp_next  = exp_reg - EXP_W'(1);
                end else begin
                    mant_next  = norm_reg[SUM_W-1 -: MANT_W];
                    frac_next  = '0;
                    iter_next  = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                prod_next  = mant_reg * mant_reg;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                mant_next = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
                frac_next = frac_step;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(FRAC_W - 1)) begin
                    if (!phase_reg) begin
                        lg_sum_next = lg_done;
                        norm_next   = {{(SUM_W-CNT_W){1'b0}}, cnt_reg};
                        exp_next    = EXP_W'(SUM_W - 1);
                        phase_next  = 1'b1;
                        state_next  = ST_NORM;
                    end else begin
                        lg_cnt_next = lg_done;
                        state_next  = ST_DIFF;
                    end
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_DIFF: begin
                d_next = $signed({{(D_W-LG_W){1'b0}}, lg_sum_reg})
                       - $signed({{(D_W-LG_W){1'b0}}, lg_cnt_reg})
                       - D_W'(LOG_BIAS);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                t_next     = d_reg * $signed(19'(DB_PER_LOG2));
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    level_next    = lvl_sat;
                    bcnt_next     = cnt_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg  <= phase_next;
        zero_reg   <= zero_next;
        norm_reg   <= norm_next;
        exp_reg    <= exp_next;
        mant_reg   <= mant_next;
        prod_reg   <= prod_next;
        frac_reg   <= frac_next;
        iter_reg   <= iter_next;
        lg_sum_reg <= lg_sum_next;
        lg_cnt_reg <= lg_cnt_next;
        cnt_reg    <= cnt_next;
        d_reg      <= d_next;
        t_reg      <= t_next;
        level_reg  <= level_next;
        bcnt_reg   <= bcnt_next;
    end

    assign m_tvalid    = m_tvalid_reg;
    assign rssi_level  = $signed(level_reg);
    assign block_count = bcnt_reg;

`ifndef SYNTHESIS
    a_norm_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NORM) |-> (norm_reg != '0))
        else $error("normalizing a zero value");
    a_mant_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ) |-> mant_reg[MANT_W-1])
        else $error("mantissa not normalized before squaring");
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(level_reg)))
        else $error("held result overwritten");
    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE && q_valid))
        else $error("queue popped outside idle");
`endif

endmodule

>>> design/block_rssi_power_db.sv
// Top level of the RSSI estimator: mean power of a sample block in 1/256 dB.
// Depends on rssi_db_pkg, rssi_db_front, rssi_db_queue, rssi_db_back.
//
//  Channel  | Dir | tdata (low bit up)                 | tlast
//  ---------+-----+------------------------------------+--------------------
//  s_       | in  | [15:0] sample_i, [31:16] sample_q  | last_sample
//  m_       | out | [15:0] rssi_level, [31:16] block_count | none
//
// Samples: one transfer per cycle; the front squares into a register and then
//   accumulates. A block end waits only when the 2-entry block queue is full.
// Result: the back takes one block at a time; a zero-power block goes straight
//   to output, others pass the shared normalize unit (8 or 1 bit a cycle)
//   and 2 x 16 squaring steps through one 31x31 multiplier,
//   plus difference, dB scaling and output.
// Reset (aresetn low, synchronous) clears the accumulator, counter, queue and
//   output valid. m_ stalls hold the result register; the back then waits
//   with the next result ready, and the front keeps taking samples.
module block_rssi_power_db
    import rssi_db_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample_i, [31:16] sample_q
    input  logic        s_tlast,   // last_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] rssi_level, [31:16] block_count
);

    logic                      push_valid;
    blk_t                      push_data;
    logic                      q_full;
    logic                      q_valid;
    blk_t                      q_data;
    logic                      q_pop;
    logic signed [LEVEL_W-1:0] rssi_level;
    logic        [CNT_W-1:0]   block_count;

    // Front: squaring stage and block accumulator
    rssi_db_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .sample_i    ($signed(s_tdata[15:0])),
        .sample_q    ($signed(s_tdata[31:16])),
        .last_sample (s_tlast),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    // Finished blocks wait here while the back works on the previous one
    rssi_db_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop)
    );

    // Back: log2, dB conversion, output register
    rssi_db_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .rssi_level  (rssi_level),
        .block_count (block_count)
    );

    assign m_tdata = {block_count, rssi_level};

endmodule

>>> sim/tb.sv
// Testbench for block_rssi_power_db: streams I/Q sample blocks and checks each
// block's RSSI level and sample count against an in-bench fixed-point predictor.
// Depends on rssi_db_pkg and the block_rssi_power_db RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rssi_db_pkg::*;

    localparam int HOLD_CYCLES = 800;    // long m_tready hold-off
    localparam int TAIL_CYCLES = 200;    // idle tail after the last result
    localparam int N_DIR       = 19;

    // One finished block as seen on m_tdata
    typedef struct packed {
        logic signed [LEVEL_W-1:0] rssi_level;
        logic [CNT_W-1:0]          block_count;
    } rssi_result_t;

    // Directed row: one sample, plus a hand-derived result where it is obvious
    typedef struct packed {
        logic signed [15:0] si;
        logic signed [15:0] sq;
        logic               last;
        logic               typed;
        rssi_result_t       res;
    } dir_row_t;

    typedef enum int {AMP_FULL, AMP_MID, AMP_SMALL, AMP_TINY, AMP_ZERO} amp_kind_t;

    localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
        // zero power -> floor
        '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{16'sh8000, 16'd1}},
        // both rails at negative full scale: 2^31 -> +3.01 dB - 20 dB
        '{16'sh8000, 16'sh8000, 1'b1, 1'b1, '{-16'sd4349, 16'd1}},
        // one rail at full scale: exactly 0 dBFS - 20 dB
        '{16'sh8000, 16'sh0000, 1'b1, 1'b1, '{-16'sd5120, 16'd1}},
        '{16'sh0000, 16'sh8000, 1'b1, 1'b1, '{-16'sd5120, 16'd1}},
        '{16'sh7fff, 16'sh7fff, 1'b1, 1'b0, '0},
        // one LSB: -30 octaves
        '{16'sh0001, 16'sh0000, 1'b1, 1'b1, '{-16'sd28239, 16'd1}},
        '{16'shffff, 16'shffff, 1'b1, 1'b0, '0},
        // four-sample block with mixed signs and rails
        '{16'sd100, 16'sd200, 1'b0, 1'b0, '0},
        '{-16'sd300, 16'sd50, 1'b0, 1'b0, '0},
        '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, '0},
        '{16'sd5, -16'sd5, 1'b1, 1'b0, '0},
        // leading zero sample, then power
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
        '{16'sh0000, 16'sh0001, 1'b1, 1'b0, '0},
        // three-sample block of silence
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
        '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{16'sh8000, 16'd3}},
        '{16'sh4000, 16'sh4000, 1'b1, 1'b0, '0},
        // alternating bit patterns
        '{16'sh5555, 16'shaaaa, 1'b1, 1'b0, '0},
        '{16'shaaaa, 16'sh5555, 1'b1, 1'b0, '0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [15:0] sample_i, [31:16] sample_q
    logic        s_tlast  = 1'b0;  // last_sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [15:0] rssi_level, [31:16] block_count

    // Predictor state: running block accumulator
    bit [SUM_W-1:0] acc_power;
    int             acc_count;

    rssi_result_t block_results_due[$];
    rssi_result_t seen_res;
    rssi_result_t want_res;
    int           mismatch_count = 0;
    int           samples_sent   = 0;
    bit           steady         = 1'b0;  // no idling on either side
    bit           hold_off_req   = 1'b0;  // ask the sink for one long stall

    block_rssi_power_db u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // log2(x) in Q.16 by repeated squaring of the normalized mantissa; x != 0
    function automatic longint log2_fix16(input bit [63:0] x);
        int        msb;
        int        b;
        int        k;
        bit [63:0] mant;
        longint    frac;
        msb  = 0;
        frac = 0;
        for (b = 0; b < 64; b++)
            if (x[b]) msb = b;
        mant = (msb > 30) ? (x >> (msb - 30)) : (x << (30 - msb));
        for (k = 0; k < FRAC_W; k++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= 64'h8000_0000) begin
                mant = mant >> 1;
                frac = frac | 1;
            end
        end
        return longint'(msb) * 65536 + frac;
    endfunction

    // Mean power over the block in 1/256 dB, 20 dB down, saturated to 16 bits
    function automatic logic signed [LEVEL_W-1:0] mean_power_level(
        input bit [SUM_W-1:0] sum, input int cnt);
        longint d;
        longint t;
        longint r;
        if (sum == 0)
            return 16'sh8000;
        d = log2_fix16(64'(sum)) - log2_fix16(64'(cnt)) - longint'(LOG_BIAS);
        t = d * longint'(DB_PER_LOG2);
        r = (t + (longint'(1) << 23)) >>> 24;   // round half up
        r = r - OFFSET_20DB;
        if (r < -32768) r = -32768;
        if (r > 32767)  r = 32767;
        return r[LEVEL_W-1:0];
    endfunction

    // Add one sample to the running block; returns 1 when the block closes
    function automatic bit fold_sample(input logic signed [15:0] si,
                                       input logic signed [15:0] sq,
                                       input bit last, output rssi_result_t res);
        longint pwr;
        bit     closes;
        pwr = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
        acc_power = acc_power + SUM_W'(pwr);
        acc_count++;
        res = '0;
        // overlong block: closes on reaching MAX_BLOCK regardless of tlast
        closes = last || (acc_count >= MAX_BLOCK);
        if (!closes)
            return 1'b0;
        res.rssi_level  = mean_power_level(acc_power, acc_count);
        res.block_count = CNT_W'(acc_count);
        acc_power = '0;
        acc_count = 0;
        return 1'b1;
    endfunction

    // Offer one sample after a random gap; queue its block result on acceptance.
    // A hand-derived result, when given, replaces the predicted one.
    task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq,
                               input bit last, input bit typed = 1'b0,
                               input rssi_result_t fixed_res = '0);
        int           gap;
        rssi_result_t res;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sq, si};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        if (fold_sample(si, sq, last, res))
            block_results_due.push_back(typed ? fixed_res : res);
    endtask

    task automatic send_random_block();
        amp_kind_t          kind;
        int                 pick;
        int                 len;
        int                 n;
        logic signed [15:0] si;
        logic signed [15:0] sq;
        pick = $urandom_range(0, 10);
        kind = (pick < 5) ? AMP_FULL : (pick < 7) ? AMP_MID : (pick < 9) ? AMP_SMALL :
               (pick < 10) ? AMP_TINY : AMP_ZERO;
        // mostly short blocks, now and then a few hundred samples
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
        for (n = 0; n < len; n++) begin
            case (kind)
                AMP_FULL: begin
                    si = 16'($urandom);
                    sq = 16'($urandom);
                end
                AMP_MID: begin
                    si = 16'(int'($urandom_range(0, 1024)) - 512);
                    sq = 16'(int'($urandom_range(0, 1024)) - 512);
                end
                AMP_SMALL: begin
                    si = 16'(int'($urandom_range(0, 16)) - 8);
                    sq = 16'(int'($urandom_range(0, 16)) - 8);
                end
                // sparse single LSBs: pushes long blocks below the level floor
                AMP_TINY: begin
                    si = ($urandom_range(0, 31) == 0) ? 16'sd1 : 16'sd0;
                    sq = ($urandom_range(0, 31) == 0) ? -16'sd1 : 16'sd0;
                end
                default: begin
                    si = '0;
                    sq = '0;
                end
            endcase
            send_sample(si, sq, n == len - 1);
        end
    endtask

    // Sender goes quiet until every queued block result has come out
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        wait (block_results_due.size() == 0);
        @(posedge aclk);
    endtask

    // Result sink: random stalls per transfer, one long hold-off on request
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Result checker: every m_ transfer against the oldest pending block result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_res.rssi_level  = m_tdata[15:0];
            seen_res.block_count = m_tdata[31:16];
            if (block_results_due.size() == 0) begin
                $error("result with no block pending: rssi_level %0d block_count %0d",
                       $signed(seen_res.rssi_level), seen_res.block_count);
                mismatch_count++;
            end else begin
                want_res = block_results_due.pop_front();
                if (seen_res.rssi_level !== want_res.rssi_level) begin
                    $error("rssi_level: expected %0d, got %0d",
                           $signed(want_res.rssi_level), $signed(seen_res.rssi_level));
                    mismatch_count++;
                end
                if (seen_res.block_count !== want_res.block_count) begin
                    $error("block_count: expected %0d, got %0d",
                           want_res.block_count, seen_res.block_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int r;
        int mark;
        acc_power = '0;
        acc_count = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: rails, zero power, single LSB, bit patterns
        for (r = 0; r < N_DIR; r++)
            send_sample(DIR_ROWS[r].si, DIR_ROWS[r].sq, DIR_ROWS[r].last,
                        DIR_ROWS[r].typed, DIR_ROWS[r].res);
        pause_until_drained();

        mark = samples_sent;
        while (samples_sent < mark + 650)
            send_random_block();

        // sink holds off while one-sample blocks pile up in the block queue
        hold_off_req = 1'b1;
        steady = 1'b1;
        repeat (24)
            send_sample(16'($urandom), 16'($urandom), 1'b1);
        steady = 1'b0;
        pause_until_drained();

        steady = 1'b1;
        mark = samples_sent;
        while (samples_sent < mark + 300)
            send_random_block();
        steady = 1'b0;
        mark = samples_sent;
        while (samples_sent < mark + 650)
            send_random_block();

        s_tvalid <= 1'b0;
        wait (block_results_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
